FILE: rtl/gcsr_pkg.sv
// ----------------------------------------------------------------------------
// gcsr_pkg
// Shared widths, defaults and codes for the gated comparator shift register.
// ----------------------------------------------------------------------------
package gcsr_pkg;

    localparam int REG_BITS_DEFAULT = 8;
    localparam int SHOW_BITS        = 8;
    localparam int VOLT_BITS        = 16;
    localparam int THRESH_BITS      = 15;
    localparam int AMOUNT_BITS      = 16;
    localparam int FRAC_BITS        = 14;
    localparam int CMP_BITS         = 34;
    localparam int APB_ADDR_BITS    = 5;
    localparam int APB_DATA_BITS    = 32;

    localparam logic [1:0] LOOP_OR  = 2'd0;
    localparam logic [1:0] LOOP_AND = 2'd1;
    localparam logic [1:0] LOOP_XOR = 2'd2;

    localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd0;
    localparam logic [2:0] REG_CV_AMOUNT       = 3'd1;
    localparam logic [2:0] REG_LOOP_SWITCH     = 3'd2;
    localparam logic [2:0] REG_LOOP_MODE       = 3'd3;
    localparam logic [2:0] REG_MELODY_MASK     = 3'd4;
    localparam logic [2:0] REG_GATE_HIGH_LEVEL = 3'd5;
    localparam logic [2:0] REG_GATE_LOW_LEVEL  = 3'd6;

    localparam logic signed [VOLT_BITS-1:0] GATE_HIGH_RESET = 16'sd4096;
    localparam logic signed [VOLT_BITS-1:0] GATE_LOW_RESET  = 16'sd205;

endpackage

FILE: rtl/gated_comparator_shift_register_top.sv
// ----------------------------------------------------------------------------
// gated_comparator_shift_register_top
// Each sample word compares a voltage against a CV-modulated threshold,
// optionally combines the result with a Schmitt-gated loop input, and shifts
// the resulting bit into a register on each rising edge of the gated clock.
// The block takes one word per clock cycle while the output is not stalled.
// A word passes through an input register and a result register, where its
// result is presented; the single 16 x 16 multiply and the 34-bit compare
// between those registers set the cycle time. Configuration is written over
// the APB port only while no word is in flight, which the user must ensure.
// ----------------------------------------------------------------------------
module gated_comparator_shift_register_top #(
    parameter int REG_BITS = gcsr_pkg::REG_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [gcsr_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  logic [gcsr_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [gcsr_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready,

    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [gcsr_pkg::VOLT_BITS-1:0]     compare_voltage,
    input  logic signed [gcsr_pkg::VOLT_BITS-1:0]     cv_voltage,
    input  logic signed [gcsr_pkg::VOLT_BITS-1:0]     clock_voltage,
    input  logic signed [gcsr_pkg::VOLT_BITS-1:0]     loop_voltage,
    input  logic signed [gcsr_pkg::VOLT_BITS-1:0]     loop_enable_voltage,
    input  logic                                      loop_enable_connected,

    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic                                      compare_gate,
    output logic                                      combined_state,
    output logic [gcsr_pkg::SHOW_BITS-1:0]            register_bits,
    output logic [gcsr_pkg::SHOW_BITS-1:0]            melody_code,
    output logic                                      loop_active
);

    localparam int WideBits = (REG_BITS > gcsr_pkg::SHOW_BITS) ? REG_BITS
                                                               : gcsr_pkg::SHOW_BITS;

    logic signed [gcsr_pkg::THRESH_BITS-1:0]  threshold_level_reg;
    logic signed [gcsr_pkg::AMOUNT_BITS-1:0]  cv_amount_reg;
    logic                                     loop_switch_reg;
    logic [1:0]                               loop_mode_reg;
    logic [gcsr_pkg::SHOW_BITS-1:0]           melody_mask_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    gate_high_level_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    gate_low_level_reg;

    logic                                     cfg_write;
    logic [2:0]                               cfg_sel;

    logic                                     s1_valid_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    s1_compare_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    s1_cv_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    s1_clock_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    s1_loop_reg;
    logic signed [gcsr_pkg::VOLT_BITS-1:0]    s1_enable_reg;
    logic                                     s1_connected_reg;

    logic [REG_BITS-1:0]                      bit_register_reg;
    logic [REG_BITS-1:0]                      bit_register_next;
    logic                                     clock_gate_reg;
    logic                                     clock_gate_next;
    logic                                     loop_gate_reg;
    logic                                     loop_gate_next;
    logic                                     loop_enable_gate_reg;
    logic                                     loop_enable_gate_next;

    logic                                     out_valid_reg;
    logic                                     compare_gate_reg;
    logic                                     combined_state_reg;
    logic [gcsr_pkg::SHOW_BITS-1:0]           register_bits_reg;
    logic [gcsr_pkg::SHOW_BITS-1:0]           register_bits_next;
    logic [gcsr_pkg::SHOW_BITS-1:0]           melody_code_reg;
    logic                                     loop_active_reg;

    logic                                     out_ready;
    logic                                     advance;
    logic                                     in_accept;

    logic signed [2*gcsr_pkg::VOLT_BITS-1:0]  cv_product;
    logic signed [gcsr_pkg::CMP_BITS-1:0]     cmp_lhs;
    logic signed [gcsr_pkg::CMP_BITS-1:0]     cmp_rhs;
    logic                                     comp;
    logic                                     active;
    logic                                     state;
    logic                                     clock_rise;
    logic [WideBits-1:0]                      wide_bits;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_level_reg <= '0;
            cv_amount_reg       <= '0;
            loop_switch_reg     <= 1'b0;
            loop_mode_reg       <= gcsr_pkg::LOOP_OR;
            melody_mask_reg     <= '0;
            gate_high_level_reg <= gcsr_pkg::GATE_HIGH_RESET;
            gate_low_level_reg  <= gcsr_pkg::GATE_LOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                gcsr_pkg::REG_THRESHOLD_LEVEL: threshold_level_reg <= pwdata[14:0];
                gcsr_pkg::REG_CV_AMOUNT:       cv_amount_reg       <= pwdata[15:0];
                gcsr_pkg::REG_LOOP_SWITCH:     loop_switch_reg     <= pwdata[0];
                gcsr_pkg::REG_LOOP_MODE:       loop_mode_reg       <= pwdata[1:0];
                gcsr_pkg::REG_MELODY_MASK:     melody_mask_reg     <= pwdata[7:0];
                gcsr_pkg::REG_GATE_HIGH_LEVEL: gate_high_level_reg <= pwdata[15:0];
                gcsr_pkg::REG_GATE_LOW_LEVEL:  gate_low_level_reg  <= pwdata[15:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            gcsr_pkg::REG_THRESHOLD_LEVEL: prdata = 32'(threshold_level_reg);
            gcsr_pkg::REG_CV_AMOUNT:       prdata = 32'(cv_amount_reg);
            gcsr_pkg::REG_LOOP_SWITCH:     prdata = 32'(loop_switch_reg);
            gcsr_pkg::REG_LOOP_MODE:       prdata = 32'(loop_mode_reg);
            gcsr_pkg::REG_MELODY_MASK:     prdata = 32'(melody_mask_reg);
            gcsr_pkg::REG_GATE_HIGH_LEVEL: prdata = 32'(gate_high_level_reg);
            gcsr_pkg::REG_GATE_LOW_LEVEL:  prdata = 32'(gate_low_level_reg);
            default:                       prdata = '0;
        endcase
    end

    // Handshake: the input register moves into the result register whenever
    // the result register is empty or its word is being taken.
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_compare_reg   <= compare_voltage;
            s1_cv_reg        <= cv_voltage;
            s1_clock_reg     <= clock_voltage;
            s1_loop_reg      <= loop_voltage;
            s1_enable_reg    <= loop_enable_voltage;
            s1_connected_reg <= loop_enable_connected;
        end
    end

    // Comparator and gate logic.
    always_comb
    begin
        cv_product = s1_cv_reg * cv_amount_reg;
        cmp_lhs    = gcsr_pkg::CMP_BITS'(s1_compare_reg) <<< gcsr_pkg::FRAC_BITS;
        cmp_rhs    = (gcsr_pkg::CMP_BITS'(threshold_level_reg) <<< gcsr_pkg::FRAC_BITS)
                     + gcsr_pkg::CMP_BITS'(cv_product);
        comp       = cmp_lhs > cmp_rhs;

        loop_enable_gate_next = loop_enable_gate_reg;
        if (s1_connected_reg)
        begin
            if (loop_enable_gate_reg)
                loop_enable_gate_next = !(s1_enable_reg <= gate_low_level_reg);
            else
                loop_enable_gate_next = s1_enable_reg >= gate_high_level_reg;
        end
        active = s1_connected_reg ? loop_enable_gate_next : loop_switch_reg;

        loop_gate_next = loop_gate_reg;
        state          = comp;
        if (active)
        begin
            if (loop_gate_reg)
                loop_gate_next = !(s1_loop_reg <= gate_low_level_reg);
            else
                loop_gate_next = s1_loop_reg >= gate_high_level_reg;
            case (loop_mode_reg)
                gcsr_pkg::LOOP_AND: state = comp && loop_gate_next;
                gcsr_pkg::LOOP_XOR: state = comp ^ loop_gate_next;
                default:            state = comp || loop_gate_next;
            endcase
        end

        clock_rise = !clock_gate_reg && (s1_clock_reg >= gate_high_level_reg);
        if (clock_gate_reg)
            clock_gate_next = !(s1_clock_reg <= gate_low_level_reg);
        else
            clock_gate_next = clock_rise;

        bit_register_next = bit_register_reg;
        if (clock_rise)
            bit_register_next = {bit_register_reg[REG_BITS-2:0], state};

        wide_bits          = WideBits'(bit_register_next);
        register_bits_next = wide_bits[gcsr_pkg::SHOW_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_register_reg     <= '0;
            clock_gate_reg       <= 1'b0;
            loop_gate_reg        <= 1'b0;
            loop_enable_gate_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                bit_register_reg     <= bit_register_next;
                clock_gate_reg       <= clock_gate_next;
                loop_gate_reg        <= loop_gate_next;
                loop_enable_gate_reg <= loop_enable_gate_next;
                out_valid_reg        <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            compare_gate_reg   <= comp;
            combined_state_reg <= state;
            register_bits_reg  <= register_bits_next;
            melody_code_reg    <= register_bits_next & melody_mask_reg;
            loop_active_reg    <= active;
        end
    end

    assign out_valid      = out_valid_reg;
    assign compare_gate   = compare_gate_reg;
    assign combined_state = combined_state_reg;
    assign register_bits  = register_bits_reg;
    assign melody_code    = melody_code_reg;
    assign loop_active    = loop_active_reg;

    // The shift register only moves when a word passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(bit_register_reg))
        else $error("shift register changed without a word advancing");

    // A word that advances always produces a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word did not reach the result register");

    // The input side stalls only when both stages are full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline could move");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gated comparator shift register. Sample words
// are sent over the valid/stall input port while configuration is written over
// APB between bursts. A local predictor tracks the Schmitt gates and the shift
// register, and each returned word is checked field by field, in order, under
// several sender and receiver idling mixes and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int REG_W          = gcsr_pkg::REG_BITS_DEFAULT;
    localparam int VOLT_BITS      = gcsr_pkg::VOLT_BITS;
    localparam int SHOW_BITS      = gcsr_pkg::SHOW_BITS;
    localparam int THRESH_BITS    = gcsr_pkg::THRESH_BITS;
    localparam int AMOUNT_BITS    = gcsr_pkg::AMOUNT_BITS;
    localparam int APB_ADDR_BITS  = gcsr_pkg::APB_ADDR_BITS;
    localparam int APB_DATA_BITS  = gcsr_pkg::APB_DATA_BITS;
    localparam int CYCLE_LIMIT    = 500000;
    localparam logic [1:0] LOOP_UNUSED = 2'd3;

    typedef struct {
        logic signed [VOLT_BITS-1:0] compare_voltage;
        logic signed [VOLT_BITS-1:0] cv_voltage;
        logic signed [VOLT_BITS-1:0] clock_voltage;
        logic signed [VOLT_BITS-1:0] loop_voltage;
        logic signed [VOLT_BITS-1:0] loop_enable_voltage;
        logic                        loop_enable_connected;
    } sample_t;

    typedef struct {
        logic                 compare_gate;
        logic                 combined_state;
        logic [SHOW_BITS-1:0] register_bits;
        logic [SHOW_BITS-1:0] melody_code;
        logic                 loop_active;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]    paddr = '0;
    logic [APB_DATA_BITS-1:0]    pwdata = '0;
    logic [APB_DATA_BITS-1:0]    prdata;
    logic                        pready;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [VOLT_BITS-1:0] compare_voltage = '0;
    logic signed [VOLT_BITS-1:0] cv_voltage = '0;
    logic signed [VOLT_BITS-1:0] clock_voltage = '0;
    logic signed [VOLT_BITS-1:0] loop_voltage = '0;
    logic signed [VOLT_BITS-1:0] loop_enable_voltage = '0;
    logic                        loop_enable_connected = 1'b0;

    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        compare_gate;
    logic                        combined_state;
    logic [SHOW_BITS-1:0]        register_bits;
    logic [SHOW_BITS-1:0]        melody_code;
    logic                        loop_active;

    // Predictor copy of the configuration and state.
    logic signed [THRESH_BITS-1:0] thr_level = '0;
    logic signed [AMOUNT_BITS-1:0] cv_amt = '0;
    logic                          loop_sw = 1'b0;
    logic [1:0]                    loop_md = gcsr_pkg::LOOP_OR;
    logic [SHOW_BITS-1:0]          mel_mask = '0;
    logic signed [VOLT_BITS-1:0]   gate_hi = gcsr_pkg::GATE_HIGH_RESET;
    logic signed [VOLT_BITS-1:0]   gate_lo = gcsr_pkg::GATE_LOW_RESET;
    logic [REG_W-1:0]              shift_reg = '0;
    logic                          clk_gate = 1'b0;
    logic                          lp_gate = 1'b0;
    logic                          en_gate = 1'b0;

    result_t pending_results[$];

    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    gated_comparator_shift_register_top uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .compare_voltage       (compare_voltage),
        .cv_voltage            (cv_voltage),
        .clock_voltage         (clock_voltage),
        .loop_voltage          (loop_voltage),
        .loop_enable_voltage   (loop_enable_voltage),
        .loop_enable_connected (loop_enable_connected),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .compare_gate          (compare_gate),
        .combined_state        (combined_state),
        .register_bits         (register_bits),
        .melody_code           (melody_code),
        .loop_active           (loop_active)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        error_count++;
        $display("Mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_checked, got_val, want_val);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (compare_gate !== want.compare_gate)
                    report_mismatch("compare_gate", int'(compare_gate),
                                    int'(want.compare_gate));
                if (combined_state !== want.combined_state)
                    report_mismatch("combined_state", int'(combined_state),
                                    int'(want.combined_state));
                if (register_bits !== want.register_bits)
                    report_mismatch("register_bits", int'(register_bits),
                                    int'(want.register_bits));
                if (melody_code !== want.melody_code)
                    report_mismatch("melody_code", int'(melody_code),
                                    int'(want.melody_code));
                if (loop_active !== want.loop_active)
                    report_mismatch("loop_active", int'(loop_active),
                                    int'(want.loop_active));
            end
        end
    end

    function automatic logic gate_next(input logic g, input logic signed [VOLT_BITS-1:0] v);
        if (g)
            return !(v <= gate_lo);
        return v >= gate_hi;
    endfunction

    task automatic predict_shift_result(input sample_t s);
        result_t r;
        longint  lhs;
        longint  rhs;
        logic    comp;
        logic    state;
        logic    active;
        logic    clk_next;
        lhs = longint'(s.compare_voltage) * 16384;
        rhs = longint'(thr_level) * 16384 + longint'(s.cv_voltage) * longint'(cv_amt);
        comp = lhs > rhs;
        state = comp;
        if (s.loop_enable_connected)
        begin
            en_gate = gate_next(en_gate, s.loop_enable_voltage);
            active = en_gate;
        end
        else
        begin
            active = loop_sw;
        end
        if (active)
        begin
            lp_gate = gate_next(lp_gate, s.loop_voltage);
            case (loop_md)
                gcsr_pkg::LOOP_AND: state = comp & lp_gate;
                gcsr_pkg::LOOP_XOR: state = comp ^ lp_gate;
                default:            state = comp | lp_gate;
            endcase
        end
        clk_next = gate_next(clk_gate, s.clock_voltage);
        if (clk_next && !clk_gate)
            shift_reg = {shift_reg[REG_W-2:0], state};
        clk_gate = clk_next;
        r.compare_gate = comp;
        r.combined_state = state;
        r.register_bits = shift_reg[SHOW_BITS-1:0];
        r.melody_code = shift_reg[SHOW_BITS-1:0] & mel_mask;
        r.loop_active = active;
        pending_results.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        case (idx)
            gcsr_pkg::REG_THRESHOLD_LEVEL: thr_level = data[THRESH_BITS-1:0];
            gcsr_pkg::REG_CV_AMOUNT:       cv_amt = data[AMOUNT_BITS-1:0];
            gcsr_pkg::REG_LOOP_SWITCH:     loop_sw = data[0];
            gcsr_pkg::REG_LOOP_MODE:       loop_md = data[1:0];
            gcsr_pkg::REG_MELODY_MASK:     mel_mask = data[SHOW_BITS-1:0];
            gcsr_pkg::REG_GATE_HIGH_LEVEL: gate_hi = data[VOLT_BITS-1:0];
            gcsr_pkg::REG_GATE_LOW_LEVEL:  gate_lo = data[VOLT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int thr, input int amt, input int sw, input logic [1:0] md,
                              input int mask, input int hi, input int lo);
        write_reg(gcsr_pkg::REG_THRESHOLD_LEVEL, 32'(thr));
        write_reg(gcsr_pkg::REG_CV_AMOUNT, 32'(amt));
        write_reg(gcsr_pkg::REG_LOOP_SWITCH, 32'(sw));
        write_reg(gcsr_pkg::REG_LOOP_MODE, 32'(md));
        write_reg(gcsr_pkg::REG_MELODY_MASK, 32'(mask));
        write_reg(gcsr_pkg::REG_GATE_HIGH_LEVEL, 32'(hi));
        write_reg(gcsr_pkg::REG_GATE_LOW_LEVEL, 32'(lo));
    endtask

    task automatic send_word(input sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        compare_voltage <= s.compare_voltage;
        cv_voltage <= s.cv_voltage;
        clock_voltage <= s.clock_voltage;
        loop_voltage <= s.loop_voltage;
        loop_enable_voltage <= s.loop_enable_voltage;
        loop_enable_connected <= s.loop_enable_connected;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        predict_shift_result(s);
    endtask

    task automatic finish_burst();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [VOLT_BITS-1:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return VOLT_BITS'(v);
    endfunction

    function automatic sample_t mk_word(input int cmp, input int cv, input int clkv,
                                        input int loopv, input int env, input bit conn);
        sample_t s;
        s.compare_voltage = VOLT_BITS'(cmp);
        s.cv_voltage = VOLT_BITS'(cv);
        s.clock_voltage = VOLT_BITS'(clkv);
        s.loop_voltage = VOLT_BITS'(loopv);
        s.loop_enable_voltage = VOLT_BITS'(env);
        s.loop_enable_connected = conn;
        return s;
    endfunction

    function automatic logic signed [VOLT_BITS-1:0] pick_gate_voltage();
        case ($urandom_range(7))
            0: return gate_hi;
            1: return gate_lo;
            2: return clamp16(longint'(gate_hi) - 1);
            3: return clamp16(longint'(gate_lo) + 1);
            4: return 16'sh7FFF;
            5: return 16'sh8000;
            default: return VOLT_BITS'($urandom);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        longint  target;
        int      offset;
        s.cv_voltage = VOLT_BITS'($urandom);
        if ($urandom_range(1) == 1)
        begin
            target = (longint'(thr_level) * 16384 + longint'(s.cv_voltage) * longint'(cv_amt))
                     / 16384;
            offset = $urandom_range(4);
            s.compare_voltage = clamp16(target + offset - 2);
        end
        else
        begin
            s.compare_voltage = VOLT_BITS'($urandom);
        end
        s.clock_voltage = pick_gate_voltage();
        s.loop_voltage = pick_gate_voltage();
        s.loop_enable_voltage = pick_gate_voltage();
        s.loop_enable_connected = 1'($urandom_range(1));
        return s;
    endfunction

    task automatic randomize_config();
        int thr;
        int amt;
        int hi;
        int lo;
        int mask;
        case ($urandom_range(4))
            0: thr = -16384;
            1: thr = 16383;
            2: thr = int'($signed(15'($urandom)));
            default: thr = int'($urandom_range(20480)) - 10240;
        endcase
        case ($urandom_range(6))
            0: amt = -32768;
            1: amt = 32767;
            2: amt = 16384;
            3: amt = -16384;
            4: amt = int'($signed(16'($urandom)));
            default: amt = int'($urandom_range(32768)) - 16384;
        endcase
        case ($urandom_range(7))
            0:
            begin
                hi = 32767;
                lo = -32768;
            end
            1:
            begin
                hi = -32768;
                lo = 32767;
            end
            2:
            begin
                hi = int'($urandom_range(2000)) - 1000;
                lo = hi + int'($urandom_range(3000));
            end
            3:
            begin
                hi = int'($signed(16'($urandom)));
                lo = int'($signed(16'($urandom)));
            end
            default:
            begin
                hi = int'($urandom_range(8192)) + 256;
                lo = hi - 1 - int'($urandom_range(6000));
            end
        endcase
        case ($urandom_range(4))
            0: mask = 0;
            1: mask = 8'hFF;
            default: mask = $urandom_range(255);
        endcase
        set_config(thr, amt, $urandom_range(1), 2'($urandom_range(3)), mask, hi, lo);
    endtask

    task automatic test_reset_defaults();
        send_word(mk_word(300, 1000, 8000, 8000, 8000, 1));
        send_word(mk_word(-300, -1000, 0, 0, 0, 0));
        send_word(mk_word(1, 0, 4096, 4096, 4096, 1));
        send_word(mk_word(0, 0, 205, 205, 205, 1));
        finish_burst();
    endtask

    task automatic test_directed();
        set_config(0, 16384, 1, gcsr_pkg::LOOP_OR, 8'hA5, 4096, 205);
        send_word(mk_word(32767, -32768, 32767, -32768, -32768, 0));
        send_word(mk_word(-32768, 32767, -32768, 32767, 0, 0));
        send_word(mk_word(100, 100, 4096, 0, 0, 0));
        send_word(mk_word(101, 100, 205, 205, 0, 0));
        finish_burst();
        set_config(2048, -16384, 1, gcsr_pkg::LOOP_AND, 8'hFF, 4096, 205);
        send_word(mk_word(4000, 2000, 5000, 5000, 0, 0));
        send_word(mk_word(4000, 2000, 0, 0, 0, 0));
        send_word(mk_word(-100, 0, 6000, 0, 0, 0));
        finish_burst();
        set_config(-2048, 8192, 1, gcsr_pkg::LOOP_XOR, 8'h0F, 4096, 205);
        send_word(mk_word(0, 0, 0, 4095, 0, 0));
        send_word(mk_word(0, 0, 8000, 8000, 0, 0));
        send_word(mk_word(-4096, 0, 0, 8000, 0, 0));
        finish_burst();
        set_config(0, 0, 1, LOOP_UNUSED, 8'h3C, 4096, 205);
        send_word(mk_word(1, 0, 8000, 8000, 0, 0));
        send_word(mk_word(-1, 0, 0, 0, 0, 0));
        finish_burst();
        set_config(0, 16384, 0, gcsr_pkg::LOOP_OR, 8'hFF, 4096, 205);
        send_word(mk_word(-1, 0, 8000, 8000, 0, 1));
        send_word(mk_word(-1, 0, 0, 8000, 8000, 1));
        send_word(mk_word(-1, 0, 8000, 0, 8000, 0));
        send_word(mk_word(-1, 0, 0, 8000, 205, 1));
        finish_burst();
        set_config(0, 0, 1, gcsr_pkg::LOOP_OR, 8'hFF, -100, 100);
        send_word(mk_word(0, 0, 0, 0, 0, 0));
        send_word(mk_word(0, 0, 0, 0, 0, 0));
        send_word(mk_word(0, 0, -32768, -32768, 0, 0));
        finish_burst();
        set_config(-16384, -32768, 0, gcsr_pkg::LOOP_XOR, 8'hFF, 32767, -32768);
        send_word(mk_word(-32768, -32768, 32767, 0, 0, 0));
        send_word(mk_word(32767, 32767, -32768, 0, 0, 0));
        finish_burst();
        set_config(16383, 32767, 1, gcsr_pkg::LOOP_AND, 8'hFF, -32768, 32767);
        send_word(mk_word(32767, -32768, 0, 0, 0, 0));
        send_word(mk_word(-32768, 32767, 0, 0, 0, 1));
        finish_burst();
    endtask

    task automatic test_random_traffic(input int words, input int idle_pct, input int stall);
        int sent;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < words)
        begin
            finish_burst();
            randomize_config();
            repeat (75) send_word(random_sample());
            sent += 75;
        end
        finish_burst();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        randomize_config();
        hold_request = 200;
        repeat (80) send_word(random_sample());
        finish_burst();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_traffic(500, 0, 0);
        test_random_traffic(450, 71, 0);
        test_random_traffic(450, 0, 71);
        test_random_traffic(450, 35, 35);
        test_backpressure();
        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d words: reset values, directed cases,",
                 results_checked, words_sent);
        $display("four idling mixes and a long output hold, over %0d register writes.",
                 reg_writes);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gcsr_pkg.sv
rtl/gated_comparator_shift_register_top.sv
bench/tb_top.sv
